/* rtl/core/hex_number_formatter_defines.svh */
// assertion macros shared by the formatter rtl
// expects clk and rst in the scope where a macro is used
`ifndef HEX_NUMBER_FORMATTER_DEFINES_SVH
`define HEX_NUMBER_FORMATTER_DEFINES_SVH

// condition implies consequence in the same cycle
`define HNF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hex formatter check failed");

// condition implies consequence in the next cycle
`define HNF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hex formatter check failed");

`endif

/* rtl/core/hnf_pkg.sv */
// package for the hex number formatter: widths, character codes, shifter control types
// no dependencies
`timescale 1ns / 1ps

package hnf_pkg;

  localparam int VALUE_W     = 64;
  localparam int NIBBLES     = VALUE_W / 4;
  localparam int NDIG_W      = $clog2(NIBBLES + 1);
  localparam int FIELD_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int MAX_FIELD_D = 62;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;

  // control from the sequencer to the nibble shifter
  typedef struct packed {
    logic load;
    logic shift;
  } hnf_shift_ctrl_t;

  // status from the nibble shifter
  typedef struct packed {
    logic [3:0]        top_nibble;
    logic [NDIG_W-1:0] ndig;
  } hnf_shift_stat_t;

  // ascii digit for one nibble
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (nib < 4'd10) begin
      return CH_ZERO + {4'd0, nib};
    end
    return base + {4'd0, nib} - 8'd10;
  endfunction

endpackage

/* rtl/core/hnf_if.sv */
// valid/ready channel interfaces for the hex number formatter
// depends on hnf_pkg
`timescale 1ns / 1ps

interface hnf_in_if;
  logic                          valid;
  logic                          ready;
  logic [hnf_pkg::VALUE_W-1:0]   value;
  logic [hnf_pkg::FIELD_W-1:0]   field_width;
  logic [hnf_pkg::FIELD_W-1:0]   min_digits;
  logic                          has_precision;
  logic                          left_justify;
  logic                          zero_pad;
  logic                          alt_form;
  logic                          upper_case;
  logic                          pointer_mode;

  modport source(
    output valid, value, field_width, min_digits, has_precision, left_justify,
           zero_pad, alt_form, upper_case, pointer_mode,
    input  ready
  );
  modport sink(
    input  valid, value, field_width, min_digits, has_precision, left_justify,
           zero_pad, alt_form, upper_case, pointer_mode,
    output ready
  );
endinterface

interface hnf_out_if;
  logic                        valid;
  logic                        ready;
  logic [hnf_pkg::CHAR_W-1:0]  out_char;
  logic                        last_char;

  modport source(output valid, out_char, last_char, input ready);
  modport sink(input valid, out_char, last_char, output ready);
endinterface

/* rtl/core/hnf_nibble_shifter.sv */
// shared nibble shifter: holds the value, strips leading zero nibbles, feeds digits msb first
// depends on hnf_pkg
`timescale 1ns / 1ps

module hnf_nibble_shifter (
  input  logic                        clk,
  input  logic                        rst,
  input  hnf_pkg::hnf_shift_ctrl_t    ctrl,
  input  logic [hnf_pkg::VALUE_W-1:0] load_value,
  output hnf_pkg::hnf_shift_stat_t    stat
);
  import hnf_pkg::*;

  logic [VALUE_W-1:0] val;
  logic [NDIG_W-1:0]  ndig;

  // load or shift one nibble toward the top
  always_ff @(posedge clk) begin
    if (rst) begin
      ndig <= '0;
    end else if (ctrl.load) begin
      ndig <= NDIG_W'(NIBBLES);
    end else if (ctrl.shift) begin
      ndig <= ndig - 1'b1;
    end
    if (ctrl.load) begin
      val <= load_value;
    end else if (ctrl.shift) begin
      val <= {val[VALUE_W-5:0], 4'd0};
    end
  end

  assign stat.top_nibble = val[VALUE_W-1 -: 4];
  assign stat.ndig       = ndig;

endmodule

/* rtl/core/hex_number_formatter.sv */
// top level of the hex number formatter (printf %x / %X conversion)
// depends on hnf_pkg, hnf_if, hnf_nibble_shifter and the assertion macro header
`timescale 1ns / 1ps
`include "hex_number_formatter_defines.svh"

// Usage
//   request: one transaction carries a 64-bit value with width, precision and flags.
//   result:  one transaction per ascii character of the field; last_char marks the
//            final one. A zero value with precision 0, no prefix and width 0 gives
//            no result transaction at all.
// Timing
//   After a request is taken the shared nibble shifter strips leading zero
//   nibbles, one per cycle. The sequencer then sizes the field in its size
//   state, and one character leaves per cycle while the receiver is ready, up
//   to 64 characters. The next request can be taken as soon as the sequencer
//   is back in idle, which it enters as the last character is registered.
//   request.ready is high only while no conversion is in progress; the last
//   character may still wait in the output register when the next request is taken.
// Reset and stall
//   rst is synchronous and returns the block to idle with no result pending.
//   While result.ready is low a full output register holds its character and
//   the sequencer waits; an empty one still takes the next character.
module hex_number_formatter #(
  parameter int MAX_FIELD = hnf_pkg::MAX_FIELD_D
) (
  input  logic      clk,
  input  logic      rst,
  hnf_in_if.sink    request,
  hnf_out_if.source result
);
  import hnf_pkg::*;

  localparam int CNT_W = $clog2(MAX_FIELD + 3);
  localparam logic [FIELD_W-1:0] MAX_F = FIELD_W'(MAX_FIELD);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SIZE,
    ST_EMIT
  } state_t;

  state_t state;

  // captured request fields
  logic [FIELD_W-1:0] width_q;
  logic [FIELD_W-1:0] prec_q;
  logic               has_prec;
  logic               left;
  logic               zpad;
  logic               alt;
  logic               upper;
  logic               ptr;
  logic               is_zero;

  // segment counters of the field
  logic [CNT_W-1:0] lead_cnt;
  logic [CNT_W-1:0] pre_cnt;
  logic [CNT_W-1:0] zero_cnt;
  logic [CNT_W-1:0] dig_cnt;
  logic [CNT_W-1:0] trail_cnt;
  logic [CNT_W-1:0] total;

  // output register
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;

  hnf_shift_ctrl_t shift_ctrl;
  hnf_shift_stat_t shift_stat;

  logic in_fire;
  logic out_free;
  logic emit_fire;

  assign in_fire   = request.valid && request.ready;
  assign out_free  = !out_valid || result.ready;
  assign emit_fire = (state == ST_EMIT) && out_free;

  // saturate width and precision
  logic [FIELD_W-1:0] width_sat;
  logic [FIELD_W-1:0] prec_sat;
  assign width_sat = (request.field_width > MAX_F) ? MAX_F : request.field_width;
  assign prec_sat  = (request.min_digits > MAX_F) ? MAX_F : request.min_digits;

  // scan step: drop a leading zero nibble while more than one digit remains
  logic scan_step;
  assign scan_step = (state == ST_SCAN) && (shift_stat.top_nibble == 4'd0)
                     && (shift_stat.ndig > NDIG_W'(1));

  // field sizing from the scanned digit count
  logic [CNT_W-1:0] width_c;
  logic [CNT_W-1:0] prec_c;
  logic [CNT_W-1:0] prefix_n;
  logic [CNT_W-1:0] ndig_eff;
  logic [CNT_W-1:0] zeros0;
  logic [CNT_W-1:0] body0;
  logic [CNT_W-1:0] zeros_n;
  logic [CNT_W-1:0] body_n;
  logic [CNT_W-1:0] pad_n;
  logic [CNT_W-1:0] total_n;

  always_comb begin
    width_c  = CNT_W'(width_q);
    prec_c   = CNT_W'(prec_q);
    prefix_n = (alt && (!is_zero || ptr)) ? CNT_W'(2) : '0;
    ndig_eff = (is_zero && has_prec && (prec_q == '0) && (prefix_n == '0))
               ? '0 : CNT_W'(shift_stat.ndig);
    zeros0   = (has_prec && (prec_c > ndig_eff)) ? (prec_c - ndig_eff) : '0;
    body0    = prefix_n + zeros0 + ndig_eff;
    zeros_n  = zeros0;
    body_n   = body0;
    if (zpad && !has_prec && !left && (width_c > body0)) begin
      zeros_n = zeros0 + (width_c - body0);
      body_n  = width_c;
    end
    pad_n   = (width_c > body_n) ? (width_c - body_n) : '0;
    total_n = pad_n + body_n;
  end

  // pick the next character by segment order
  logic [CHAR_W-1:0] next_char;
  logic              take_lead;
  logic              take_pre;
  logic              take_zero;
  logic              take_dig;

  always_comb begin
    take_lead = 1'b0;
    take_pre  = 1'b0;
    take_zero = 1'b0;
    take_dig  = 1'b0;
    next_char = CH_SPACE;
    if (lead_cnt != '0) begin
      take_lead = 1'b1;
    end else if (pre_cnt != '0) begin
      take_pre  = 1'b1;
      next_char = (pre_cnt == CNT_W'(2)) ? CH_ZERO : (upper ? CH_X_UP : CH_X_LO);
    end else if (zero_cnt != '0) begin
      take_zero = 1'b1;
      next_char = CH_ZERO;
    end else if (dig_cnt != '0) begin
      take_dig  = 1'b1;
      next_char = hex_char(shift_stat.top_nibble, upper);
    end
  end

  // shared shifter control
  assign shift_ctrl.load  = in_fire;
  assign shift_ctrl.shift = scan_step || (emit_fire && take_dig);

  hnf_nibble_shifter u_shifter (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (shift_ctrl),
    .load_value (request.value),
    .stat       (shift_stat)
  );

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      total     <= '0;
      lead_cnt  <= '0;
      pre_cnt   <= '0;
      zero_cnt  <= '0;
      dig_cnt   <= '0;
      trail_cnt <= '0;
    end else begin
      // drained output register empties unless a new character lands
      if (result.ready && !emit_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            width_q  <= width_sat;
            prec_q   <= prec_sat;
            has_prec <= request.has_precision;
            left     <= request.left_justify;
            zpad     <= request.zero_pad;
            alt      <= request.alt_form;
            upper    <= request.upper_case;
            ptr      <= request.pointer_mode;
            is_zero  <= (request.value == '0);
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!scan_step) begin
            state <= ST_SIZE;
          end
        end
        ST_SIZE: begin
          lead_cnt  <= left ? '0 : pad_n;
          trail_cnt <= left ? pad_n : '0;
          pre_cnt   <= prefix_n;
          zero_cnt  <= zeros_n;
          dig_cnt   <= ndig_eff;
          total     <= total_n;
          state     <= (total_n == '0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_char  <= next_char;
            out_last  <= (total == CNT_W'(1));
            total     <= total - 1'b1;
            if (take_lead) begin
              lead_cnt <= lead_cnt - 1'b1;
            end else if (take_pre) begin
              pre_cnt <= pre_cnt - 1'b1;
            end else if (take_zero) begin
              zero_cnt <= zero_cnt - 1'b1;
            end else if (take_dig) begin
              dig_cnt <= dig_cnt - 1'b1;
            end else begin
              trail_cnt <= trail_cnt - 1'b1;
            end
            if (total == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign request.ready    = (state == ST_IDLE);
  assign result.valid     = out_valid;
  assign result.out_char  = out_char;
  assign result.last_char = out_last;

  // checks on the sequencer bookkeeping
  `HNF_ASSERT_SAME(a_emit_sum, state == ST_EMIT,
    total == lead_cnt + pre_cnt + zero_cnt + dig_cnt + trail_cnt)
  `HNF_ASSERT_SAME(a_emit_nonempty, state == ST_EMIT, total != '0)
  `HNF_ASSERT_NEXT(a_last_to_idle, emit_fire && (total == CNT_W'(1)),
    (state == ST_IDLE) && out_valid && out_last)
  `HNF_ASSERT_SAME(a_digits_fit, state == ST_EMIT,
    dig_cnt <= CNT_W'(shift_stat.ndig))

endmodule

/* tb/sv/hnf_fmt_checker.sv */
// checker for the hex number formatter: watches request and result channels,
// predicts each conversion's characters and compares them in order
// depends on hnf_pkg and hnf_if
`timescale 1ns / 1ps

module hnf_fmt_checker (
  input  logic clk,
  input  logic rst,
  hnf_in_if    request,
  hnf_out_if   result,
  output int   fail_count,
  output int   pending_chars
);
  import hnf_pkg::*;

  localparam int FIELD_CAP = MAX_FIELD_D;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } field_char_t;

  field_char_t field_q[$];

  initial begin
    fail_count    = 0;
    pending_chars = 0;
  end

  // build the printf %x field for one conversion and queue its characters
  function automatic void queue_field_chars(
    input logic [VALUE_W-1:0] v,
    input logic [FIELD_W-1:0] w_raw,
    input logic [FIELD_W-1:0] p_raw,
    input logic hp, lj, zp, af, uc, pm
  );
    int width, prec, ndig, prefix, zeros, body, pad;
    logic [CHAR_W-1:0] chars[$];
    logic [3:0] nib;
    field_char_t fc;
    width = (w_raw > FIELD_CAP) ? FIELD_CAP : int'(w_raw);
    prec  = (p_raw > FIELD_CAP) ? FIELD_CAP : int'(p_raw);

    // digit count: highest nonzero nibble, at least one digit
    ndig = 1;
    for (int i = 1; i < NIBBLES; i++) begin
      if (v[4*i +: 4] != 4'd0) ndig = i + 1;
    end

    prefix = (af && (v != '0 || pm)) ? 2 : 0;
    // zero with explicit precision 0 and no prefix prints no digit
    if (v == '0 && hp && prec == 0 && prefix == 0) ndig = 0;

    zeros = (hp && prec > ndig) ? prec - ndig : 0;
    body  = prefix + zeros + ndig;
    // zero padding only when right-justified and no precision
    if (zp && !hp && !lj && width > body) begin
      zeros += width - body;
      body   = width;
    end
    pad = (width > body) ? width - body : 0;

    if (!lj) repeat (pad) chars.push_back(CH_SPACE);
    if (prefix != 0) begin
      chars.push_back(CH_ZERO);
      chars.push_back(uc ? CH_X_UP : CH_X_LO);
    end
    repeat (zeros) chars.push_back(CH_ZERO);
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if (nib < 4'd10) chars.push_back(CH_ZERO + CHAR_W'(nib));
      else chars.push_back((uc ? CH_A_UP : CH_A_LO) + CHAR_W'(nib) - 8'd10);
    end
    if (lj) repeat (pad) chars.push_back(CH_SPACE);

    foreach (chars[i]) begin
      fc.ch   = chars[i];
      fc.last = (i == chars.size() - 1);
      field_q.push_back(fc);
    end
  endfunction

  // compare result transactions first, then predict accepted requests
  always @(posedge clk) begin
    field_char_t exp_c;
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (field_q.size() == 0) begin
          $display("%0t: unexpected char: got %h last %b", $time,
                   result.out_char, result.last_char);
          fail_count++;
        end else begin
          exp_c = field_q.pop_front();
          if (result.out_char !== exp_c.ch || result.last_char !== exp_c.last) begin
            $display("%0t: char mismatch: expected %h last %b, got %h last %b", $time,
                     exp_c.ch, exp_c.last, result.out_char, result.last_char);
            fail_count++;
          end
        end
      end
      if (request.valid && request.ready) begin
        queue_field_chars(request.value, request.field_width, request.min_digits,
                          request.has_precision, request.left_justify, request.zero_pad,
                          request.alt_form, request.upper_case, request.pointer_mode);
      end
    end
    pending_chars <= field_q.size();
  end

endmodule

/* tb/sv/tb.sv */
// testbench top for the hex number formatter: clock, reset, request stimulus,
// result back-pressure and verdict; depends on hnf_pkg, hnf_if and hnf_fmt_checker
`timescale 1ns / 1ps

module tb;
  import hnf_pkg::*;

  localparam int RAND_PER_PHASE = 70;
  localparam int SETTLE_CYCLES  = 100;
  localparam int RX_HOLD_CYCLES = 300;

  typedef enum logic [1:0] {PH_RX_HEAVY, PH_TX_HEAVY, PH_FULL_RATE} idle_phase_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_chars;
  int   tx_idle_pct;
  int   rx_hold_left;
  bit   rx_hold_done;
  idle_phase_t phase;

  hnf_in_if  req_ch();
  hnf_out_if res_ch();

  hex_number_formatter u_top (
    .clk    (clk),
    .rst    (rst),
    .request(req_ch),
    .result (res_ch)
  );

  hnf_fmt_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .request      (req_ch),
    .result       (res_ch),
    .fail_count   (fail_count),
    .pending_chars(pending_chars)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // result back-pressure, with one long hold at the start of full rate
  initial begin
    res_ch.ready <= 1'b0;
    rx_hold_left = 0;
    rx_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == PH_FULL_RATE && !rx_hold_done) begin
        rx_hold_left = RX_HOLD_CYCLES;
        rx_hold_done = 1'b1;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (phase)
          PH_RX_HEAVY: res_ch.ready <= ($urandom_range(99) >= 53);
          PH_TX_HEAVY: res_ch.ready <= ($urandom_range(99) >= 33);
          default:     res_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // offer one conversion, idling at random first, and wait for the transaction
  task automatic offer_conv(
    input logic [VALUE_W-1:0] v,
    input logic [FIELD_W-1:0] w,
    input logic [FIELD_W-1:0] p,
    input logic hp, lj, zp, af, uc, pm
  );
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.value         <= v;
    req_ch.field_width   <= w;
    req_ch.min_digits    <= p;
    req_ch.has_precision <= hp;
    req_ch.left_justify  <= lj;
    req_ch.zero_pad      <= zp;
    req_ch.alt_form      <= af;
    req_ch.upper_case    <= uc;
    req_ch.pointer_mode  <= pm;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // random conversion: varied digit counts, mostly modest widths
  task automatic offer_random_conv();
    logic [VALUE_W-1:0] v;
    logic [FIELD_W-1:0] w, p;
    int nd;
    v  = {$urandom, $urandom};
    nd = $urandom_range(0, 16);
    if ($urandom_range(3) != 0) v = (nd == 0) ? '0 : v >> (4 * (16 - nd));
    w = ($urandom_range(9) == 0) ? FIELD_W'($urandom_range(25, 63))
                                 : FIELD_W'($urandom_range(0, 24));
    p = ($urandom_range(9) == 0) ? FIELD_W'($urandom_range(25, 63))
                                 : FIELD_W'($urandom_range(0, 20));
    offer_conv(v, w, p, 1'($urandom_range(1)), 1'($urandom_range(1)),
               1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
               1'($urandom_range(1)));
  endtask

  // stop offering and wait until every expected character has come
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin
    req_ch.valid         <= 1'b0;
    req_ch.value         <= '0;
    req_ch.field_width   <= '0;
    req_ch.min_digits    <= '0;
    req_ch.has_precision <= 1'b0;
    req_ch.left_justify  <= 1'b0;
    req_ch.zero_pad      <= 1'b0;
    req_ch.alt_form      <= 1'b0;
    req_ch.upper_case    <= 1'b0;
    req_ch.pointer_mode  <= 1'b0;
    phase       <= PH_RX_HEAVY;
    tx_idle_pct = 33;
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: zero value cases
    offer_conv('0, 6'd0, 6'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);   // nothing printed
    offer_conv('0, 6'd5, 6'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);   // only spaces
    offer_conv('0, 6'd3, 6'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_conv('0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_conv('0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);   // prefix dropped
    offer_conv('0, 6'd0, 6'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);   // pointer keeps prefix
    offer_conv('0, 6'd10, 6'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
    offer_conv('0, 6'd0, 6'd5, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    // directed: extremes of value, width and precision
    offer_conv('1, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    offer_conv('1, 6'd62, 6'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    offer_conv(64'h0123_4567_89ab_cdef, 6'd63, 6'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    offer_conv(64'h1, 6'd0, 6'd63, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    offer_conv(64'h1, 6'd63, 6'd62, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    offer_conv(64'h8000_0000_0000_0000, 6'd17, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    // directed: precision cancels zero padding, left justify ignores it
    offer_conv(64'hbeef, 6'd20, 6'd4, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    offer_conv(64'hbeef, 6'd20, 6'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    offer_conv(64'hdead_beef, 6'd12, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    offer_conv(64'ha, 6'd1, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_conv(64'habc, 6'd8, 6'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    offer_conv(64'h5555_aaaa_5555_aaaa, 6'd42, 6'd21, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    offer_conv(64'haaaa_5555_aaaa_5555, 6'd21, 6'd42, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);

    // random, sender idles less than receiver
    repeat (RAND_PER_PHASE) offer_random_conv();
    wait_drained();

    // random, roles swapped
    phase       <= PH_TX_HEAVY;
    tx_idle_pct = 53;
    repeat (RAND_PER_PHASE) offer_random_conv();
    wait_drained();

    // random at full rate, opening with a long receiver hold
    phase       <= PH_FULL_RATE;
    tx_idle_pct = 0;
    repeat (RAND_PER_PHASE) offer_random_conv();
    wait_drained();

    if (fail_count == 0 && pending_chars == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
